/* sv/hsc_pkg.sv */
`default_nettype none

package hsc_pkg;

  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BRICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BRICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_BRICKS  = 2'd2;

  typedef struct packed {
    logic               voxel_filled;
    logic [COLOR_W-1:0] voxel_color;
    logic               flush;
  } hsc_in_t;

  typedef struct packed {
    logic               kept_filled;
    logic [COLOR_W-1:0] kept_color;
    logic               last_voxel;
  } hsc_out_t;

  typedef struct packed {
    logic has_result;
    logic in_flush;
    logic zin_odd;
    logic x_first;
    logic x_last;
    logic y_first;
    logic y_last;
    logic z_first;
    logic last_voxel;
  } hsc_flags_t;

endpackage

`default_nettype wire

/* sv/voxel_hidden_surface_cull_core.sv */
`default_nettype none

// Six-neighbor boundary extraction over a voxel volume streamed in raster order
// (x fastest, then y, then z). The core takes one word per clock unless output
// stalls, and returns the result for voxel (x,y,z) via the stage-one and output
// registers once the word for (x,y,z+1) is taken, so results trail the input by
// one plane; the host appends one plane of flush words after the volume. Two
// planes of occupancy sit in two copies of a row-wide memory with two read ports
// each, one plane of colors in one memory; every word reads and writes each, but
// flush-plane words write no color. A dimension register write restarts the
// stream at the origin; the user makes it only when idle, unchecked by the core.
module voxel_hidden_surface_cull_core import hsc_pkg::*; #(
  parameter int BRICK_EDGE   = 8,
  parameter int MAX_VOXELS_X = 128,
  parameter int MAX_VOXELS_Y = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire hsc_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hsc_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW       = $clog2(MAX_VOXELS_X);
  localparam int YW       = $clog2(MAX_VOXELS_Y);
  localparam int ROW_BITS = 1 << XW;

  logic [XW-1:0]       pos_x;
  logic [YW-1:0]       pos_y;
  hsc_flags_t          flags;
  logic                accept;
  logic                filled_in;
  logic                slot_cur;
  logic                slot_in;
  logic [ROW_BITS-1:0] row_up;
  logic [ROW_BITS-1:0] row_dn;
  logic [ROW_BITS-1:0] row_self;
  logic [ROW_BITS-1:0] row_below;
  logic [COLOR_W-1:0]  color_rd;

  logic                s1_valid_r, s1_valid_nxt;
  hsc_flags_t          s1_flags_r;
  logic [XW-1:0]       s1_x_r;
  logic                s1_filled_r;
  logic                s1_move;
  logic [XW-1:0]       xm;
  logic [XW-1:0]       xp;
  logic                open;
  logic                kept;

  logic                out_valid_r, out_valid_nxt;
  hsc_out_t            out_data_r;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign filled_in = in_data.voxel_filled && !in_data.flush && !flags.in_flush;
  assign slot_in   = flags.zin_odd;
  assign slot_cur  = !flags.zin_odd;

  hsc_seq #(
    .BRICK_EDGE   (BRICK_EDGE),
    .MAX_VOXELS_X (MAX_VOXELS_X),
    .MAX_VOXELS_Y (MAX_VOXELS_Y)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .flags     (flags)
  );

  hsc_occ_mem #(
    .ADDR_W (YW + 1),
    .COL_W  (XW)
  ) u_occ_vert (
    .clk       (clk),
    .wr_en     (accept),
    .wr_row    ({slot_in, pos_y}),
    .wr_col    (pos_x),
    .wr_bit    (filled_in),
    .rd_en     (accept),
    .rd_row_a  ({slot_cur, pos_y - 1'b1}),
    .rd_row_b  ({slot_cur, pos_y + 1'b1}),
    .rd_data_a (row_up),
    .rd_data_b (row_dn)
  );

  hsc_occ_mem #(
    .ADDR_W (YW + 1),
    .COL_W  (XW)
  ) u_occ_row (
    .clk       (clk),
    .wr_en     (accept),
    .wr_row    ({slot_in, pos_y}),
    .wr_col    (pos_x),
    .wr_bit    (filled_in),
    .rd_en     (accept),
    .rd_row_a  ({slot_cur, pos_y}),
    .rd_row_b  ({slot_in, pos_y}),
    .rd_data_a (row_self),
    .rd_data_b (row_below)
  );

  hsc_color_mem #(
    .ADDR_W (YW + XW)
  ) u_color (
    .clk     (clk),
    .wr_en   (accept && !flags.in_flush),
    .rd_en   (accept),
    .addr    ({pos_y, pos_x}),
    .wr_data (in_data.voxel_color),
    .rd_data (color_rd)
  );

  assign s1_move  = s1_valid_r && (!s1_flags_r.has_result || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r  <= flags;
      s1_x_r      <= pos_x;
      s1_filled_r <= filled_in;
    end
  end

  assign xm = s1_x_r - 1'b1;
  assign xp = s1_x_r + 1'b1;

  always_comb begin
    open = s1_flags_r.x_first || !row_self[xm] ||
           s1_flags_r.x_last  || !row_self[xp] ||
           s1_flags_r.y_first || !row_up[s1_x_r] ||
           s1_flags_r.y_last  || !row_dn[s1_x_r] ||
           s1_flags_r.z_first || !row_below[s1_x_r] ||
           !s1_filled_r;
    kept = row_self[s1_x_r] && open;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move && s1_flags_r.has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_flags_r.has_result) begin
      out_data_r.kept_filled <= kept;
      out_data_r.kept_color  <= kept ? color_rd : '0;
      out_data_r.last_voxel  <= s1_flags_r.last_voxel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* sv/hsc_occ_mem.sv */
`default_nettype none

module hsc_occ_mem #(
  parameter int ADDR_W = 8,
  parameter int COL_W  = 7
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_row,
  input  wire logic [COL_W-1:0]      wr_col,
  input  wire logic                  wr_bit,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     rd_row_a,
  input  wire logic [ADDR_W-1:0]     rd_row_b,
  output logic      [(1<<COL_W)-1:0] rd_data_a,
  output logic      [(1<<COL_W)-1:0] rd_data_b
);

  logic [(1<<COL_W)-1:0] mem [1<<ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_bit;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_row_a];
      rd_data_b <= mem[rd_row_b];
    end
  end

endmodule

`default_nettype wire

/* sv/hsc_color_mem.sv */
`default_nettype none

module hsc_color_mem import hsc_pkg::*; #(
  parameter int ADDR_W = 14
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  addr,
  input  wire logic [COLOR_W-1:0] wr_data,
  output logic      [COLOR_W-1:0] rd_data
);

  logic [COLOR_W-1:0] mem [1<<ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* sv/hsc_seq.sv */
`default_nettype none

module hsc_seq import hsc_pkg::*; #(
  parameter int BRICK_EDGE   = 8,
  parameter int MAX_VOXELS_X = 128,
  parameter int MAX_VOXELS_Y = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0]           cfg_data,
  input  wire logic                            advance,
  output logic      [$clog2(MAX_VOXELS_X)-1:0] pos_x,
  output logic      [$clog2(MAX_VOXELS_Y)-1:0] pos_y,
  output hsc_flags_t                           flags
);

  localparam int XW = $clog2(MAX_VOXELS_X);
  localparam int YW = $clog2(MAX_VOXELS_Y);
  localparam int WW = $clog2(MAX_VOXELS_X + 1);
  localparam int HW = $clog2(MAX_VOXELS_Y + 1);
  localparam int DW = $clog2(64 * BRICK_EDGE + 1);

  function automatic int dim_voxels(int bricks, int maxb, int maxv);
    int b;
    int v;
    b = bricks;
    if (b < 1) b = 1;
    if (b > maxb) b = maxb;
    v = b * BRICK_EDGE;
    if (maxv != 0 && v > maxv) v = maxv;
    return v;
  endfunction

  logic [WW-1:0] w_r, w_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [DW-1:0] z_r, z_nxt;
  logic          cfg_hit;
  logic          x_last;
  logic          y_last;
  logic          in_flush;

  assign cfg_hit  = cfg_valid && (cfg_index == CFG_WIDTH_BRICKS ||
                    cfg_index == CFG_HEIGHT_BRICKS || cfg_index == CFG_DEPTH_BRICKS);
  assign x_last   = (WW'(x_r) == w_r - 1'b1);
  assign y_last   = (HW'(y_r) == h_r - 1'b1);
  assign in_flush = (z_r >= d_r);

  always_comb begin
    w_nxt = w_r;
    h_nxt = h_r;
    d_nxt = d_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH_BRICKS: begin
          w_nxt = WW'(dim_voxels(int'(cfg_data[4:0]), 16, MAX_VOXELS_X));
        end
        CFG_HEIGHT_BRICKS: begin
          h_nxt = HW'(dim_voxels(int'(cfg_data[4:0]), 16, MAX_VOXELS_Y));
        end
        CFG_DEPTH_BRICKS: begin
          d_nxt = DW'(dim_voxels(int'(cfg_data), 64, 0));
        end
        default: begin
        end
      endcase
    end
    if (cfg_hit) begin
      x_nxt = '0;
      y_nxt = '0;
      z_nxt = '0;
    end else if (advance) begin
      if (x_last) begin
        x_nxt = '0;
        if (y_last) begin
          y_nxt = '0;
          z_nxt = in_flush ? '0 : z_r + 1'b1;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end else begin
        x_nxt = x_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WW'(dim_voxels(16, 16, MAX_VOXELS_X));
      h_r <= HW'(dim_voxels(16, 16, MAX_VOXELS_Y));
      d_r <= DW'(dim_voxels(16, 64, 0));
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else begin
      w_r <= w_nxt;
      h_r <= h_nxt;
      d_r <= d_nxt;
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign pos_x = x_r;
  assign pos_y = y_r;

  always_comb begin
    flags.has_result = (z_r != '0);
    flags.in_flush   = in_flush;
    flags.zin_odd    = z_r[0];
    flags.x_first    = (x_r == '0);
    flags.x_last     = x_last;
    flags.y_first    = (y_r == '0);
    flags.y_last     = y_last;
    flags.z_first    = (z_r == DW'(1));
    flags.last_voxel = x_last && y_last && (z_r == d_r);
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;
  import hsc_pkg::*;

  localparam int VOX_PER_BRICK = 8;
  localparam int ROW_CELLS     = 128;
  localparam int COL_CELLS     = 128;
  localparam int PLANE_CELLS   = ROW_CELLS * COL_CELLS;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 50000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  class surface_board;
    int unsigned wide_reg;
    int unsigned high_reg;
    int unsigned deep_reg;
    int unsigned col_x;
    int unsigned row_y;
    int unsigned slab_z;
    int unsigned errors;
    bit occ_plane [2][PLANE_CELLS];
    bit [COLOR_W-1:0] tint_plane [PLANE_CELLS];
    hsc_out_t pending_surface [$];

    function new();
      wide_reg = 16;
      high_reg = 16;
      deep_reg = 16;
    endfunction

    function int unsigned span(int unsigned bricks, int unsigned maxb, int unsigned maxv);
      int unsigned b;
      int unsigned v;
      b = bricks;
      if (b < 1) b = 1;
      if (b > maxb) b = maxb;
      v = b * VOX_PER_BRICK;
      if (maxv != 0 && v > maxv) v = maxv;
      return v;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WIDTH_BRICKS: wide_reg = 32'(val[4:0]);
        CFG_HEIGHT_BRICKS: high_reg = 32'(val[4:0]);
        CFG_DEPTH_BRICKS: deep_reg = 32'(val);
        default: return;
      endcase
      col_x = 0;
      row_y = 0;
      slab_z = 0;
    endfunction

    function void note_voxel(hsc_in_t v);
      int unsigned w, h, d, x, y, zin, z, addr, cur;
      bit fill, open, self_occ;
      hsc_out_t e;
      w = span(wide_reg, 16, ROW_CELLS);
      h = span(high_reg, 16, COL_CELLS);
      d = span(deep_reg, 64, 0);
      x = col_x;
      y = row_y;
      zin = slab_z;
      if (x >= w) x = w - 1;
      if (y >= h) y = h - 1;
      if (zin > d) zin = d;
      addr = y * ROW_CELLS + x;
      fill = v.voxel_filled;
      if (v.flush || zin >= d) fill = 1'b0;
      if (zin >= 1) begin
        z = zin - 1;
        cur = z % 2;
        self_occ = occ_plane[cur][addr];
        open = (x == 0 || !occ_plane[cur][addr - 1]) ||
               (x + 1 >= w || !occ_plane[cur][addr + 1]) ||
               (y == 0 || !occ_plane[cur][addr - ROW_CELLS]) ||
               (y + 1 >= h || !occ_plane[cur][addr + ROW_CELLS]) ||
               (z == 0 || !occ_plane[zin % 2][addr]) || !fill;
        e.kept_filled = self_occ && open;
        e.kept_color = e.kept_filled ? tint_plane[addr] : '0;
        e.last_voxel = (x == w - 1 && y == h - 1 && zin == d);
        pending_surface.push_back(e);
      end
      occ_plane[zin % 2][addr] = fill;
      if (zin < d) tint_plane[addr] = v.voxel_color;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) begin
          y = 0;
          zin++;
          if (zin > d) zin = 0;
        end
      end
      col_x = x;
      row_y = y;
      slab_z = zin;
    endfunction

    function void check_result(hsc_out_t r);
      hsc_out_t e;
      if (pending_surface.size() == 0) begin
        $error("unexpected word: kept_filled=%0d kept_color=%06h last_voxel=%0d",
               r.kept_filled, r.kept_color, r.last_voxel);
        errors++;
        return;
      end
      e = pending_surface.pop_front();
      if (r.kept_filled !== e.kept_filled) begin
        $error("kept_filled expected %0d actual %0d", e.kept_filled, r.kept_filled);
        errors++;
      end
      if (r.kept_color !== e.kept_color) begin
        $error("kept_color expected %06h actual %06h", e.kept_color, r.kept_color);
        errors++;
      end
      if (r.last_voxel !== e.last_voxel) begin
        $error("last_voxel expected %0d actual %0d", e.last_voxel, r.last_voxel);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hsc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hsc_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH_BRICKS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  surface_board board;
  bit quiet = 1'b0;
  int unsigned gap_odds = 0;
  int unsigned still_cycles = 0;

  voxel_hidden_surface_cull_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 20;
    endcase
  endfunction

  task automatic send_voxel(hsc_in_t v);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (!in_ready);
    board.note_voxel(v);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.note_config(idx, val);
  endtask

  task automatic set_volume(logic [CFG_DATA_W-1:0] wb, logic [CFG_DATA_W-1:0] hb,
                            logic [CFG_DATA_W-1:0] db);
    write_reg(CFG_WIDTH_BRICKS, wb);
    write_reg(CFG_HEIGHT_BRICKS, hb);
    write_reg(CFG_DEPTH_BRICKS, db);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (board.pending_surface.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Each volume gets a random, mostly filled box so that interior voxels with all
  // six neighbors filled actually occur, with sparse noise outside the box.
  task automatic stream(int unsigned w, int unsigned h, int unsigned d,
                        int unsigned count, int unsigned quiet_from);
    int unsigned n, x, y, z;
    int unsigned lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    bit in_box;
    hsc_in_t v;
    x = 0;
    y = 0;
    z = 0;
    for (n = 0; n < count; n++) begin
      if (n % 48 == 0) gap_odds = pick_odds();
      if (n >= quiet_from) quiet = 1'b1;
      if (x == 0 && y == 0 && z == 0) begin
        lo_x = $urandom_range(0, w - 1);
        hi_x = $urandom_range(lo_x, w - 1);
        lo_y = $urandom_range(0, h - 1);
        hi_y = $urandom_range(lo_y, h - 1);
        lo_z = $urandom_range(0, d - 1);
        hi_z = $urandom_range(lo_z, d - 1);
      end
      in_box = x >= lo_x && x <= hi_x && y >= lo_y && y <= hi_y && z >= lo_z && z <= hi_z;
      v.voxel_color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      if (z < d) begin
        v.voxel_filled = in_box ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 9) == 0);
        v.flush = ($urandom_range(0, 39) == 0);
      end else begin
        v.voxel_filled = 1'($urandom_range(0, 1));
        v.flush = ($urandom_range(0, 7) != 0);
      end
      send_voxel(v);
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) begin
          y = 0;
          z++;
          if (z > d) z = 0;
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int unsigned stall_odds;
    int unsigned tick;
    stall_odds = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 64 == 0) stall_odds = pick_odds();
      if (rst_n && !quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      still_cycles <= 0;
    end else begin
      still_cycles <= still_cycles + 1;
    end
    if (still_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    hsc_in_t edge_words [8];
    hsc_in_t v;
    edge_words[0] = '{voxel_filled: 1'b1, voxel_color: 24'h000000, flush: 1'b0};
    edge_words[1] = '{voxel_filled: 1'b1, voxel_color: 24'hFFFFFF, flush: 1'b0};
    edge_words[2] = '{voxel_filled: 1'b0, voxel_color: 24'hFFFFFF, flush: 1'b0};
    edge_words[3] = '{voxel_filled: 1'b0, voxel_color: 24'h000000, flush: 1'b0};
    edge_words[4] = '{voxel_filled: 1'b1, voxel_color: 24'hAAAAAA, flush: 1'b0};
    edge_words[5] = '{voxel_filled: 1'b1, voxel_color: 24'h555555, flush: 1'b0};
    edge_words[6] = '{voxel_filled: 1'b1, voxel_color: 24'hFFFFFF, flush: 1'b1};
    edge_words[7] = '{voxel_filled: 1'b0, voxel_color: 24'h800001, flush: 1'b1};
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset geometry is 128 x 128 x 128, so these words stay in the first
    // plane and must produce no result.
    for (int i = 0; i < 24; i++) begin
      if (i < 8) begin
        v = edge_words[i];
      end else begin
        v.voxel_filled = 1'($urandom_range(0, 1));
        v.voxel_color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
        v.flush = ($urandom_range(0, 5) == 0);
      end
      send_voxel(v);
    end
    in_valid <= 1'b0;
    settle();

    // Zero brick counts clamp to one brick: an 8 x 8 x 8 volume, its flush
    // plane, and the start of the next volume after the wrap.
    set_volume(7'h00, 7'h00, 7'h00);
    stream(8, 8, 8, 9 * 64 + 40, 32'hFFFF_FFFF);
    settle();

    write_reg(CFG_SPARE, 7'h2A);
    cfg_valid <= 1'b0;

    // Width field masks to zero, height saturates at 16 bricks.
    set_volume(7'h20, 7'h1F, 7'h01);
    stream(8, 128, 8, 80, 32'hFFFF_FFFF);
    settle();

    // Full width with depth saturated; runs past the first row of the second
    // plane so the far x boundary is checked. The tail runs without gaps.
    set_volume(7'h50, 7'h41, 7'h7F);
    stream(128, 8, 512, 1024 + 144, 1024 + 144 - 300);

    while (board.pending_surface.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
